// ===== sv/brle_pkg.sv =====
// shared constants, types and header helpers for the byte run-length encoder
// no dependencies; imported by every module of the block but brle_ram
`timescale 1ns / 1ps
`default_nettype none

package brle_pkg;

   localparam int unsigned MAX_BLOCK_LEN = 126;
   localparam int unsigned OUT_LANES     = 8;
   localparam int unsigned LEN_W         = 7;
   localparam int unsigned ADDR_W        = $clog2(MAX_BLOCK_LEN);
   localparam int unsigned CNT_W         = 4;
   localparam int unsigned LANE_W        = $clog2(OUT_LANES);

   localparam logic [7:0]       LITERAL_FLAG = 8'h80;
   localparam logic [7:0]       COUNT_MASK   = 8'h7F;
   localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_BLOCK_LEN);
   localparam logic [CNT_W-1:0] FULL_CNT     = CNT_W'(OUT_LANES);

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SINGLE,
      MODE_REPEAT,
      MODE_LITERAL
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_HDR0,
      ST_BODY0,
      ST_HDR1,
      ST_BODY1
   } ctrl_state_type;

   typedef enum logic [2:0] {
      SEL_HDR0,
      SEL_VAL0,
      SEL_HDR1,
      SEL_VAL1,
      SEL_RAM
   } byte_sel_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_HOLD,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic         take;
      logic         fix_wr;
      logic         push;
      byte_sel_type sel;
      logic         final_byte;
      logic         k_clr;
      logic         k_inc;
      rd_sel_type   rd_sel;
   } cmd_type;

   typedef struct packed {
      logic s0_vld;
      logic s0_lit;
      logic s1_vld;
      logic s1_lit;
      logic lit_end;
      logic push_ok;
   } status_type;

   // count byte of a repeat run: length plus one, high bit clear
   function automatic logic [7:0] repeat_hdr(input logic [LEN_W-1:0] n);
      logic [LEN_W-1:0] n1;
      n1 = n + LEN_W'(1);
      return {1'b0, n1} & COUNT_MASK;
   endfunction

   // count byte of a literal block: length with the high bit set
   function automatic logic [7:0] literal_hdr(input logic [LEN_W-1:0] n);
      return ({1'b0, n} & COUNT_MASK) | LITERAL_FLAG;
   endfunction

endpackage

`default_nettype wire

// ===== sv/brle_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module brle_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/brle_ctrl.sv =====
// sequencer: accepts an item, then walks the headers and bodies of closed blocks
// depends on brle_pkg
`timescale 1ns / 1ps
`default_nettype none

module brle_ctrl
   import brle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type stat,
   output cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           body_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.sel    = SEL_HDR0;
      cmd.rd_sel = RD_HOLD;
      body_done  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.fix_wr = 1'b1;
            cmd.rd_sel = RD_ZERO;
            state_in   = stat.s0_vld ? ST_HDR0 : ST_IDLE;
         end
         ST_HDR0: begin
            cmd.sel    = SEL_HDR0;
            cmd.rd_sel = RD_ZERO;
            cmd.k_clr  = 1'b1;
            if (stat.push_ok) begin
               cmd.push = 1'b1;
               state_in = ST_BODY0;
            end
         end
         ST_BODY0: begin
            body_done = !stat.s0_lit || stat.lit_end;
            cmd.sel   = stat.s0_lit ? SEL_RAM : SEL_VAL0;
            if (stat.push_ok) begin
               cmd.push = 1'b1;
               if (body_done) begin
                  cmd.final_byte = !stat.s1_vld;
                  state_in       = stat.s1_vld ? ST_HDR1 : ST_IDLE;
               end else begin
                  cmd.k_inc  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end
         end
         ST_HDR1: begin
            cmd.sel    = SEL_HDR1;
            cmd.rd_sel = RD_ZERO;
            cmd.k_clr  = 1'b1;
            if (stat.push_ok) begin
               cmd.push = 1'b1;
               state_in = ST_BODY1;
            end
         end
         ST_BODY1: begin
            body_done = !stat.s1_lit || stat.lit_end;
            cmd.sel   = stat.s1_lit ? SEL_RAM : SEL_VAL1;
            if (stat.push_ok) begin
               cmd.push = 1'b1;
               if (body_done) begin
                  cmd.final_byte = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.k_inc  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/brle_dpath.sv =====
// block state, literal store and closed-block descriptors; selects the byte to pack
// depends on brle_pkg and brle_ram
`timescale 1ns / 1ps
`default_nettype none

module brle_dpath
   import brle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_stream_last,
   input  wire cmd_type    cmd,
   input  wire logic       pack_ready,
   output status_type      stat,
   output logic [7:0]      byte_out,
   output logic            last_out
);

   mode_type         mode_ff, mode_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       prev_ff, prev_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             s0_vld_ff, s0_vld_in;
   logic             s0_lit_ff, s0_lit_in;
   logic [7:0]       s0_hdr_ff, s0_hdr_in;
   logic [7:0]       s0_val_ff, s0_val_in;
   logic             s1_vld_ff, s1_vld_in;
   logic             s1_lit_ff, s1_lit_in;
   logic [7:0]       s1_hdr_ff, s1_hdr_in;
   logic [7:0]       s1_val_ff, s1_val_in;
   logic [LEN_W-1:0] lit_len_ff, lit_len_in;
   logic             fix_ff, fix_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] k_ff, k_in;

   logic             accept;
   logic [LEN_W-1:0] len_inc;
   logic             a_vld, a_lit, b_vld, b_lit;
   logic [7:0]       a_hdr, a_val, b_hdr, b_val;
   logic [LEN_W-1:0] a_len, b_len;
   logic             acc_wr;
   logic [ADDR_W-1:0] acc_addr;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   assign accept  = cmd.take && req_valid;
   assign len_inc = len_ff + LEN_W'(1);

   // next block state and the blocks closed by this byte
   always_comb begin
      mode_in  = mode_ff;
      held_in  = held_ff;
      prev_in  = prev_ff;
      len_in   = len_ff;
      a_vld    = 1'b0;
      a_lit    = 1'b0;
      a_hdr    = 8'h00;
      a_val    = held_ff;
      a_len    = len_ff;
      b_vld    = 1'b0;
      b_lit    = 1'b0;
      b_hdr    = 8'h00;
      b_val    = held_ff;
      b_len    = len_ff;
      acc_wr   = 1'b0;
      acc_addr = ADDR_W'(len_ff);
      fix_in   = fix_ff;
      if (accept) begin
         prev_in = req_data_byte;
         fix_in  = 1'b0;
         unique case (mode_ff)
            MODE_NONE: begin
               mode_in = MODE_SINGLE;
               held_in = req_data_byte;
               len_in  = LEN_W'(1);
            end
            MODE_SINGLE: begin
               len_in = LEN_W'(2);
               if (req_data_byte == held_ff) begin
                  mode_in = MODE_REPEAT;
               end else begin
                  // second byte goes in now, the held first byte in the setup cycle
                  mode_in  = MODE_LITERAL;
                  acc_wr   = 1'b1;
                  acc_addr = ADDR_W'(1);
                  fix_in   = 1'b1;
               end
            end
            MODE_REPEAT: begin
               if (req_data_byte == held_ff) begin
                  len_in = len_inc;
                  if (len_inc >= MAX_LEN) begin
                     a_vld   = 1'b1;
                     a_hdr   = repeat_hdr(len_inc);
                     mode_in = MODE_NONE;
                     len_in  = '0;
                  end
               end else begin
                  a_vld   = 1'b1;
                  a_hdr   = repeat_hdr(len_ff);
                  mode_in = MODE_SINGLE;
                  held_in = req_data_byte;
                  len_in  = LEN_W'(1);
               end
            end
            MODE_LITERAL: begin
               if (req_data_byte == prev_ff) begin
                  a_vld   = 1'b1;
                  a_lit   = 1'b1;
                  a_hdr   = literal_hdr(len_ff);
                  a_len   = len_ff;
                  mode_in = MODE_SINGLE;
                  held_in = req_data_byte;
                  len_in  = LEN_W'(1);
               end else begin
                  acc_wr = 1'b1;
                  len_in = len_inc;
                  if (len_inc >= MAX_LEN) begin
                     a_vld   = 1'b1;
                     a_lit   = 1'b1;
                     a_hdr   = literal_hdr(len_inc);
                     a_len   = len_inc;
                     mode_in = MODE_NONE;
                     len_in  = '0;
                  end
               end
            end
            default: begin
               mode_in = MODE_NONE;
            end
         endcase
         // flush whatever is still pending at the end of the stream
         if (req_stream_last) begin
            b_val = held_in;
            b_len = len_in;
            unique case (mode_in)
               MODE_SINGLE: begin
                  b_vld = 1'b1;
                  b_hdr = literal_hdr(LEN_W'(1));
               end
               MODE_REPEAT: begin
                  b_vld = 1'b1;
                  b_hdr = repeat_hdr(len_in);
               end
               MODE_LITERAL: begin
                  b_vld = 1'b1;
                  b_lit = 1'b1;
                  b_hdr = literal_hdr(len_in);
               end
               default: begin
                  b_vld = 1'b0;
               end
            endcase
            mode_in = MODE_NONE;
            len_in  = '0;
         end
      end
   end

   // pack the closed blocks into two ordered slots
   always_comb begin
      s0_vld_in  = s0_vld_ff;
      s0_lit_in  = s0_lit_ff;
      s0_hdr_in  = s0_hdr_ff;
      s0_val_in  = s0_val_ff;
      s1_vld_in  = s1_vld_ff;
      s1_lit_in  = s1_lit_ff;
      s1_hdr_in  = s1_hdr_ff;
      s1_val_in  = s1_val_ff;
      lit_len_in = lit_len_ff;
      last_in    = last_ff;
      if (accept) begin
         last_in    = req_stream_last;
         lit_len_in = a_lit ? a_len : b_len;
         if (a_vld) begin
            s0_vld_in = 1'b1;
            s0_lit_in = a_lit;
            s0_hdr_in = a_hdr;
            s0_val_in = a_val;
            s1_vld_in = b_vld;
            s1_lit_in = b_lit;
            s1_hdr_in = b_hdr;
            s1_val_in = b_val;
         end else begin
            s0_vld_in = b_vld;
            s0_lit_in = b_lit;
            s0_hdr_in = b_hdr;
            s0_val_in = b_val;
            s1_vld_in = 1'b0;
            s1_lit_in = 1'b0;
            s1_hdr_in = b_hdr;
            s1_val_in = b_val;
         end
      end
   end

   // body byte counter
   always_comb begin
      k_in = k_ff;
      if (cmd.k_clr) begin
         k_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NONE;
         held_ff   <= 8'h00;
         prev_ff   <= 8'h00;
         len_ff    <= '0;
         s0_vld_ff <= 1'b0;
         s0_lit_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s1_lit_ff <= 1'b0;
         fix_ff    <= 1'b0;
         last_ff   <= 1'b0;
         k_ff      <= '0;
      end else begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         prev_ff   <= prev_in;
         len_ff    <= len_in;
         s0_vld_ff <= s0_vld_in;
         s0_lit_ff <= s0_lit_in;
         s1_vld_ff <= s1_vld_in;
         s1_lit_ff <= s1_lit_in;
         fix_ff    <= fix_in;
         last_ff   <= last_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_hdr_ff  <= s0_hdr_in;
      s0_val_ff  <= s0_val_in;
      s1_hdr_ff  <= s1_hdr_in;
      s1_val_ff  <= s1_val_in;
      lit_len_ff <= lit_len_in;
   end

   // literal store port selection
   always_comb begin
      ram_wr_en   = acc_wr;
      ram_wr_addr = acc_addr;
      ram_wr_data = req_data_byte;
      if (cmd.fix_wr && fix_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = '0;
         ram_wr_data = held_ff;
      end
      unique case (cmd.rd_sel)
         RD_ZERO: ram_rd_addr = '0;
         RD_NEXT: ram_rd_addr = ADDR_W'(k_ff + LEN_W'(1));
         default: ram_rd_addr = ADDR_W'(k_ff);
      endcase
   end

   brle_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BLOCK_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      unique case (cmd.sel)
         SEL_HDR0: byte_out = s0_hdr_ff;
         SEL_VAL0: byte_out = s0_val_ff;
         SEL_HDR1: byte_out = s1_hdr_ff;
         SEL_VAL1: byte_out = s1_val_ff;
         SEL_RAM:  byte_out = ram_rd_data;
         default:  byte_out = ram_rd_data;
      endcase
   end

   assign last_out = last_ff;

   assign stat.s0_vld  = s0_vld_ff;
   assign stat.s0_lit  = s0_lit_ff;
   assign stat.s1_vld  = s1_vld_ff;
   assign stat.s1_lit  = s1_lit_ff;
   assign stat.lit_end = ((k_ff + LEN_W'(1)) == lit_len_ff);
   assign stat.push_ok = pack_ready;

endmodule

`default_nettype wire

// ===== sv/brle_pack.sv =====
// gathers output bytes into lane words and holds the result register
// depends on brle_pkg
`timescale 1ns / 1ps
`default_nettype none

module brle_pack
   import brle_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [7:0]       push_byte,
   input  wire logic             final_byte,
   input  wire logic             stream_last,
   output logic                  ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_lanes [OUT_LANES],
   output logic [CNT_W-1:0]      rsp_byte_count,
   output logic                  rsp_group_last,
   output logic                  rsp_stream_done
);

   logic [7:0]       lanes_ff [OUT_LANES];
   logic [7:0]       lanes_in [OUT_LANES];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic             fin_ff, fin_in;
   logic             sdone_ff, sdone_in;

   logic [7:0]       out_lanes_ff [OUT_LANES];
   logic [7:0]       out_lanes_in [OUT_LANES];
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic             out_grp_ff, out_grp_in;
   logic             out_sdone_ff, out_sdone_in;
   logic             out_vld_ff, out_vld_in;

   logic             move;
   logic [CNT_W-1:0] cnt_inc;

   assign move    = done_ff && (!out_vld_ff || !rsp_stall);
   assign cnt_inc = cnt_ff + CNT_W'(1);

   always_comb begin
      lanes_in     = lanes_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      fin_in       = fin_ff;
      sdone_in     = sdone_ff;
      out_lanes_in = out_lanes_ff;
      out_cnt_in   = out_cnt_ff;
      out_grp_in   = out_grp_ff;
      out_sdone_in = out_sdone_ff;
      out_vld_in   = out_vld_ff;
      if (push) begin
         lanes_in[cnt_ff[LANE_W-1:0]] = push_byte;
         cnt_in   = cnt_inc;
         done_in  = (cnt_inc == FULL_CNT) || final_byte;
         fin_in   = final_byte;
         sdone_in = final_byte && stream_last;
      end
      if (move) begin
         // unused lanes read as zero
         for (int i = 0; i < OUT_LANES; i++) begin
            out_lanes_in[i] = (CNT_W'(i) < cnt_ff) ? lanes_ff[i] : 8'h00;
         end
         out_cnt_in   = cnt_ff;
         out_grp_in   = fin_ff;
         out_sdone_in = sdone_ff;
         out_vld_in   = 1'b1;
         cnt_in       = '0;
         done_in      = 1'b0;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         done_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         done_ff    <= done_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff     <= lanes_in;
      fin_ff       <= fin_in;
      sdone_ff     <= sdone_in;
      out_lanes_ff <= out_lanes_in;
      out_cnt_ff   <= out_cnt_in;
      out_grp_ff   <= out_grp_in;
      out_sdone_ff <= out_sdone_in;
   end

   assign ready           = !done_ff;
   assign rsp_valid       = out_vld_ff;
   assign rsp_lanes       = out_lanes_ff;
   assign rsp_byte_count  = out_cnt_ff;
   assign rsp_group_last  = out_grp_ff;
   assign rsp_stream_done = out_sdone_ff;

endmodule

`default_nettype wire

// ===== sv/byte_rle_encoder.sv =====
// top level of the byte run-length encoder: sequencer, datapath and word packer
// depends on brle_pkg, brle_ctrl, brle_dpath, brle_pack and brle_ram
//
// usage
// - req channel: one uncompressed byte per transfer, req_stream_last on the final
//   byte flushes the pending block; req_stall is high while an item is being worked
// - rsp channel: words of up to eight code bytes, lowest lane first, rsp_byte_count
//   valid lanes, unused lanes zero; rsp_group_last marks the last word caused by a
//   byte, rsp_stream_done the last word of the stream
// - a byte that closes no block goes through transfer and setup and gives
//   no word
// - a byte that closes blocks: one code byte per cycle leaves the sequencer while
//   the packer is ready, plus a handoff at each full word from the gathering
//   register into the result register; worst case a literal of 125 closed by an
//   equal final byte, 128 code bytes in 16 words
// - literal bytes come from a 126 x 8 store with a registered read port, which
//   sets the one byte per cycle drain rate while the packer is ready
// - reset (synchronous) empties the pending block and drops any word in flight;
//   the literal store holds no valid data and needs no clearing pass
// - while the receiver stalls, the result word holds and the gathering register
//   may fill one more word; the sequencer then waits, byte by byte
`timescale 1ns / 1ps
`default_nettype none

module byte_rle_encoder
   import brle_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // input byte channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_stream_last,
   // code word channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_lane0,
   output logic [7:0]            rsp_lane1,
   output logic [7:0]            rsp_lane2,
   output logic [7:0]            rsp_lane3,
   output logic [7:0]            rsp_lane4,
   output logic [7:0]            rsp_lane5,
   output logic [7:0]            rsp_lane6,
   output logic [7:0]            rsp_lane7,
   output logic [CNT_W-1:0]      rsp_byte_count,
   output logic                  rsp_group_last,
   output logic                  rsp_stream_done
);

   cmd_type    cmd;
   status_type stat;
   logic [7:0] pack_byte;
   logic       pack_last;
   logic       pack_ready;
   logic [7:0] lanes [OUT_LANES];

   // sequencer: take an item, set up, then header and body of each closed block
   brle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // block state, literal store and descriptors of the closed blocks
   brle_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_stream_last (req_stream_last),
      .cmd             (cmd),
      .pack_ready      (pack_ready),
      .stat            (stat),
      .byte_out        (pack_byte),
      .last_out        (pack_last)
   );

   // gathering register plus result register, parting the two sides
   brle_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .push            (cmd.push),
      .push_byte       (pack_byte),
      .final_byte      (cmd.final_byte),
      .stream_last     (pack_last),
      .ready           (pack_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lanes       (lanes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_group_last  (rsp_group_last),
      .rsp_stream_done (rsp_stream_done)
   );

   // a new byte is taken only while the sequencer is idle
   assign req_stall = !cmd.take;

   assign rsp_lane0 = lanes[0];
   assign rsp_lane1 = lanes[1];
   assign rsp_lane2 = lanes[2];
   assign rsp_lane3 = lanes[3];
   assign rsp_lane4 = lanes[4];
   assign rsp_lane5 = lanes[5];
   assign rsp_lane6 = lanes[6];
   assign rsp_lane7 = lanes[7];

endmodule

`default_nettype wire

// ===== sv/brle_checker.sv =====
// port-level checks on the code word channel of the encoder, bound to the top level
// depends on brle_pkg and byte_rle_encoder
`timescale 1ns / 1ps
`default_nettype none

module brle_checker
   import brle_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [7:0]       rsp_lane0,
   input wire logic [7:0]       rsp_lane1,
   input wire logic [7:0]       rsp_lane2,
   input wire logic [7:0]       rsp_lane3,
   input wire logic [7:0]       rsp_lane4,
   input wire logic [7:0]       rsp_lane5,
   input wire logic [7:0]       rsp_lane6,
   input wire logic [7:0]       rsp_lane7,
   input wire logic [CNT_W-1:0] rsp_byte_count,
   input wire logic             rsp_group_last,
   input wire logic             rsp_stream_done
);

   // no word survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled word keeps its lanes and count
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lane0) && $stable(rsp_lane1)
         && $stable(rsp_lane2) && $stable(rsp_lane3) && $stable(rsp_lane4)
         && $stable(rsp_lane5) && $stable(rsp_lane6) && $stable(rsp_lane7)
         && $stable(rsp_byte_count) && $stable(rsp_group_last)
         && $stable(rsp_stream_done))
      else $error("stalled result word changed");

   // only the last word of a group may be short
   a_full_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_group_last |-> rsp_byte_count == FULL_CNT)
      else $error("word before end of group not full");

   // end of stream only on the last word of a group
   a_done_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_group_last)
      else $error("stream end flagged mid group");

   // every word carries at least one byte and at most a full word
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count != '0 && rsp_byte_count <= FULL_CNT)
      else $error("byte count out of range");

endmodule

bind byte_rle_encoder brle_checker u_checker (.*);

`default_nettype wire
